// File: hw/rtl/wmsa_pkg.sv
// ---------------------------------------------------------------------------
// wmsa_pkg
// Shared types and constants of the windowed sample minimum block.
// ---------------------------------------------------------------------------
package wmsa_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_VALUE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_NUM_SAMPLES  = 2'd0;
  localparam logic [1:0] REG_WINDOW_EXTRA = 2'd1;
  localparam logic [1:0] REG_VALUE_BITS   = 2'd2;

  localparam int unsigned RowMax = 65535;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_OUT,
    ST_CLR
  } state_e;

  // divider request and status
  typedef struct packed {
    logic        start;
    logic [31:0] sum;
    logic [15:0] cnt;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] mean;
    logic [16:0] ratio;
  } div_rsp_t;

endpackage

// File: hw/rtl/wmsa_div.sv
// ---------------------------------------------------------------------------
// wmsa_div
// Radix-2 restoring divider giving mean and Q1.16 ratio of a sum over a count.
// ---------------------------------------------------------------------------
module wmsa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wmsa_pkg::div_req_t req_i,
  output wmsa_pkg::div_rsp_t rsp_o
);
  import wmsa_pkg::*;

  // dividend is sum << 16, 48 bits; quotient bits beyond 17 saturate
  logic [47:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [15:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;
  logic [17:0] diff;

  always_comb begin
    trial  = {rem_q[15:0], num_q[47]};
    diff   = {1'b0, trial} - {2'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = {req_i.sum, 16'd0};
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[46:0], 1'b0};
      if (!diff[17]) begin
        rem_d = diff[16:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) den_q <= req_i.cnt;
  end

  // saturate results
  assign rsp_o.done  = done_q;
  assign rsp_o.mean  = (quo_q[47:32] != 16'd0) ? 16'hFFFF : quo_q[31:16];
  assign rsp_o.ratio = (quo_q[47:17] != 31'd0) ? 17'h1FFFF : quo_q[16:0];

endmodule

// File: hw/rtl/windowed_min_sample_abundance.sv
// ---------------------------------------------------------------------------
// windowed_min_sample_abundance
// Per-sample sliding window minimum with running sums and summary reads.
// ---------------------------------------------------------------------------
// Usage: words enter on the input channel (valid_i/stall_o) as a command,
// a sample column and a value; each word gives one result word on the
// output channel (valid_o/stall_i). Configuration words come in on
// cfg_valid_i/cfg_ready_o with a register index and data; the user is to
// send them only while idle, which the block does not enforce. History and
// sums live in two synchronous memories with a registered read port each;
// an in-range value word reads its entry, then writes it back. A read word
// runs the bit-serial divider when there are k-mers and skips it when there
// are none, and a clear word sweeps the sum memory, one entry per cycle.
// One word is in flight at a time; the next is taken once the block is
// idle and the result register is free or taken.
// After reset the sum memory is swept to zero, every entry, before the
// first word is accepted; configuration is taken any time.
// A stalled receiver holds the result register and, with it, the input.
// ---------------------------------------------------------------------------
module windowed_min_sample_abundance #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned MAX_EXTRA   = 3,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  sample_i,
  input  logic [15:0] value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] kmer_min_o,
  output logic        kmer_valid_o,
  output logic [31:0] sum_total_o,
  output logic [15:0] mean_value_o,
  output logic [16:0] ratio_fraction_o,
  output logic [15:0] kmer_number_o,
  output logic        no_kmers_o
);
  import wmsa_pkg::*;

  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned HD  = (MAX_EXTRA > 0) ? MAX_EXTRA : 1;
  localparam int unsigned VW  = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;

  // configuration registers
  logic [6:0] num_samples_q;
  logic [1:0] window_extra_q;
  logic [4:0] value_bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_samples_q  <= 7'd1;
      window_extra_q <= 2'd0;
      value_bits_q   <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NUM_SAMPLES:  num_samples_q  <= cfg_data_i;
        REG_WINDOW_EXTRA: window_extra_q <= cfg_data_i[1:0];
        REG_VALUE_BITS:   value_bits_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [10:0] eff_n;
  logic [2:0]  eff_z;
  logic [4:0]  eff_b;
  logic [15:0] vmask;
  always_comb begin
    eff_n = (num_samples_q == 7'd0) ? 11'd1 : {4'd0, num_samples_q};
    if (eff_n > 11'(MAX_SAMPLES)) eff_n = 11'(MAX_SAMPLES);
    eff_z = ({1'b0, window_extra_q} > 3'(MAX_EXTRA)) ? 3'(MAX_EXTRA) : {1'b0, window_extra_q};
    eff_b = (value_bits_q == 5'd0) ? 5'd1 : value_bits_q;
    if (eff_b > 5'(VW)) eff_b = 5'(VW);
    vmask = 16'((17'd1 << eff_b) - 17'd1);
  end

  // memories
  logic [HD*16-1:0] hist_mem [MAX_SAMPLES];
  logic [31:0]      sum_mem  [MAX_SAMPLES];
  logic [HD*16-1:0] hist_rd_q;
  logic [31:0]      sum_rd_q;
  logic             hist_we, sum_we;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [HD*16-1:0] hist_wd;
  logic [31:0]      sum_wd;

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[wr_addr] <= hist_wd;
    hist_rd_q <= hist_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[wr_addr] <= sum_wd;
    sum_rd_q <= sum_mem[rd_addr];
  end

  // control
  state_e      state_q, state_d;
  logic [1:0]  cmd_q;
  logic [5:0]  smp_q;
  logic [15:0] val_q;
  logic [15:0] row_q, row_d;
  logic [AW:0] clr_q, clr_d;
  logic        in_range;
  logic        val_hit;
  logic        out_full_q;
  logic        take;
  logic        out_load;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [15:0] kcount;
  logic [15:0] kcount_d;
  logic [31:0] rsum;

  assign kcount   = (row_q > {13'd0, eff_z}) ? row_q - {13'd0, eff_z} : 16'd0;
  assign kcount_d = (row_d > {13'd0, eff_z}) ? row_d - {13'd0, eff_z} : 16'd0;
  assign in_range = {5'd0, smp_q} < eff_n;
  assign val_hit  = (cmd_q == CMD_VALUE) && in_range;
  assign stall_o  = !(state_q == ST_IDLE && (!out_full_q || !stall_i));
  assign take     = valid_i && !stall_o;

  // read sum forced to zero past the array
  assign rsum = ({26'd0, smp_q} < 32'(MAX_SAMPLES)) ? sum_rd_q : 32'd0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take) state_d = ST_LOOK;
      ST_LOOK: begin
        if (cmd_q == CMD_CLEAR) state_d = ST_CLR;
        else state_d = ST_OUT;
      end
      ST_OUT: begin
        if (cmd_q == CMD_READ && kcount != 16'd0) state_d = ST_DIV;
        else state_d = ST_IDLE;
      end
      ST_DIV: if (drsp.done) state_d = ST_IDLE;
      ST_CLR: if (clr_q == (AW+1)'(MAX_SAMPLES - 1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // window minimum and writeback
  logic [15:0]      wmin;
  logic [HD*16-1:0] hist_sh;
  logic             full;
  logic [32:0]      sum_add;
  always_comb begin
    wmin = val_q & vmask;
    for (int i = 0; i < HD; i++) begin
      if (i < int'(eff_z) && hist_rd_q[i*16 +: 16] < wmin) wmin = hist_rd_q[i*16 +: 16];
    end
    // newest value in slot 0, older ones move up inside the window only
    hist_sh       = hist_rd_q;
    hist_sh[15:0] = val_q & vmask;
    for (int i = 1; i < HD; i++) begin
      if (i <= int'(eff_z)) hist_sh[i*16 +: 16] = hist_rd_q[(i-1)*16 +: 16];
    end
    full    = row_q >= {13'd0, eff_z};
    sum_add = {1'b0, sum_rd_q} + {17'd0, wmin};
  end

  always_comb begin
    rd_addr = AW'(sample_i);
    hist_we = 1'b0;
    sum_we  = 1'b0;
    wr_addr = AW'(smp_q);
    hist_wd = hist_sh;
    sum_wd  = sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
    row_d   = row_q;
    clr_d   = clr_q;
    dreq.start = 1'b0;
    dreq.sum   = rsum;
    dreq.cnt   = kcount;
    out_load   = 1'b0;
    case (state_q)
      ST_LOOK: begin
        if (cmd_q == CMD_CLEAR) begin
          row_d = 16'd0;
          clr_d = '0;
        end else begin
          out_load   = 1'b1;
          dreq.start = (cmd_q == CMD_READ && kcount != 16'd0);
          if (cmd_q == CMD_VALUE && in_range) begin
            hist_we = 1'b1;
            sum_we  = full;
            if ({5'd0, smp_q} == eff_n - 11'd1 && row_q != 16'(RowMax)) row_d = row_q + 16'd1;
          end
        end
      end
      ST_CLR: begin
        sum_we  = 1'b1;
        sum_wd  = '0;
        wr_addr = clr_q[AW-1:0];
        clr_d   = clr_q + 1'b1;
        if (clr_q == (AW+1)'(MAX_SAMPLES - 1)) out_load = 1'b1;
      end
      default: ;
    endcase
  end

  wmsa_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  logic rdy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      row_q      <= '0;
      clr_q      <= '0;
      cmd_q      <= CMD_NONE;
      out_full_q <= 1'b0;
      rdy_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      clr_q   <= clr_d;
      if (take) cmd_q <= command_i;
      rdy_q <= rdy_q | (state_q == ST_CLR && state_d == ST_IDLE);
      if ((out_load && (state_q != ST_CLR || rdy_q)) ||
          (state_q == ST_DIV && drsp.done))
        out_full_q <= 1'b1;
      else if (!stall_i)
        out_full_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      smp_q <= sample_i;
      val_q <= value_i;
    end
    if (state_q == ST_DIV && drsp.done) begin
      mean_value_o     <= drsp.mean;
      ratio_fraction_o <= drsp.ratio;
    end else if (out_load) begin
      kmer_min_o       <= val_hit ? wmin : 16'd0;
      kmer_valid_o     <= val_hit && full;
      sum_total_o      <= val_hit ? (full ? sum_wd : sum_rd_q) :
                          ((cmd_q == CMD_READ) ? rsum : 32'd0);
      mean_value_o     <= '0;
      ratio_fraction_o <= '0;
      no_kmers_o       <= (cmd_q == CMD_READ) && (kcount == 16'd0);
      kmer_number_o    <= kcount_d;
    end
  end

  assign valid_o = out_full_q && !(state_q == ST_DIV) &&
                   !(state_q == ST_OUT && cmd_q == CMD_READ && kcount != 16'd0);

  a_one_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> state_q == ST_LOOK) else $error("no lookup after accept");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> stall_o) else $error("accept while busy");
  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(row_q) == 16'hFFFF && state_q != ST_CLR |-> row_q == 16'hFFFF || row_q == 16'd0)
    else $error("row counter wrapped");

endmodule
